[rtl/core/ptr_pkg.sv]
package ptr_pkg;

  localparam int NumCols   = 8;
  localparam int NumPlanes = 4;
  localparam int PalRegs   = 4;
  localparam int EntryW    = 6;
  localparam int RegW      = 48;
  localparam int AddrW     = 5;
  localparam int DataW     = 64;
  localparam int ColW      = 3;
  localparam int IdxW      = 4;
  localparam int RgbW      = 24;

  typedef logic [NumCols-1:0][EntryW-1:0] pal_reg_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    logic            sprite;
    logic [ColW-1:0] col;
    logic            last;
  } cell_t;

  typedef struct packed {
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
  } apb_req_t;

  // colour index of destination column d
  function automatic logic [IdxW-1:0] lane_index(input logic [31:0] planes,
                                                 input logic mirror,
                                                 input logic [ColW-1:0] d);
    logic [ColW-1:0] src;
    logic [ColW-1:0] bitpos;
    logic [IdxW-1:0] idx;
    src    = mirror ? ~d : d;
    bitpos = ~src;
    for (int p = 0; p < NumPlanes; p++) begin
      idx[p] = planes[{p[1:0], bitpos}];
    end
    return idx;
  endfunction

  // two bits per channel, scaled by 0x55
  function automatic logic [RgbW-1:0] expand_rgb(input logic [EntryW-1:0] raw);
    return {{4{raw[1:0]}}, {4{raw[3:2]}}, {4{raw[5:4]}}};
  endfunction

endpackage

[rtl/core/ptr_in_if.sv]
interface ptr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_planes;
  logic        mirror_horizontal;
  logic        sprite_mode;

  modport source (output valid, row_planes, mirror_horizontal, sprite_mode, input ready);
  modport sink (input valid, row_planes, mirror_horizontal, sprite_mode, output ready);
endinterface

[rtl/core/ptr_out_if.sv]
interface ptr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  pixel_column;
  logic [23:0] pixel_rgb;
  logic        write_enable;
  logic        last_pixel;

  modport source (output valid, pixel_column, pixel_rgb, write_enable, last_pixel,
                  input ready);
  modport sink (input valid, pixel_column, pixel_rgb, write_enable, last_pixel,
                output ready);
endinterface

[rtl/core/ptr_cell.sv]
module ptr_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          load,
  input  ptr_pkg::cell_t load_data,
  input  ptr_pkg::cell_t from_next,
  output ptr_pkg::cell_t cur
);
  import ptr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (load) begin
      cur <= load_data;
    end else if (advance) begin
      cur <= from_next;
    end
  end

endmodule

[rtl/core/ptr_palette.sv]
module ptr_palette (
  input  logic                        clk,
  input  logic                        rst,
  input  ptr_pkg::apb_req_t           req,
  output logic [ptr_pkg::DataW-1:0]   prdata,
  input  logic [4:0]                  entry,
  output logic [ptr_pkg::EntryW-1:0]  raw
);
  import ptr_pkg::*;

  pal_reg_t pal [PalRegs];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PalRegs; i++) begin
        pal[i] <= '0;
      end
    end else if (req.psel && req.penable && req.pwrite) begin
      pal[req.paddr[4:3]] <= req.pwdata[RegW-1:0];
    end
  end

  assign prdata = {{(DataW-RegW){1'b0}}, pal[req.paddr[4:3]]};
  assign raw    = pal[entry[4:3]][entry[2:0]];

endmodule

[rtl/core/planar_tile_row_pixel_renderer.sv]
// Takes one four-bitplane tile row per item and sends out eight pixel items, one per
// cycle unless pixel.ready stalls the output, in column order 0..7, the last flagged by
// last_pixel. The row is spread over a chain of eight cells that shifts one pixel a
// cycle, while not stalled, into a registered palette lookup, and a new row is taken
// in the cycle the previous one leaves the chain.
// The four 48-bit palette registers sit at byte addresses 0, 8, 16 and 24 of the
// APB port; sprite rows use entries 16 to 31 and colour index 0 of a sprite row comes
// out with write_enable low and a black colour.
module planar_tile_row_pixel_renderer (
  input  logic        clk,
  input  logic        rst,
  ptr_in_if.sink      row,
  ptr_out_if.source   pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ptr_pkg::*;

  cell_t           cells [NumCols];
  cell_t           load_data [NumCols];
  cell_t           head;
  apb_req_t        req;
  logic            advance;
  logic            load;
  logic [EntryW-1:0] raw;

  assign pready = 1'b1;
  assign req = '{psel: psel, penable: penable, pwrite: pwrite, paddr: paddr,
                 pwdata: pwdata};

  assign advance   = !pixel.valid || pixel.ready;
  assign row.ready = advance && !cells[1].valid;
  assign load      = row.valid && row.ready;
  assign head      = cells[0];

  for (genvar d = 0; d < NumCols; d++) begin : g_chain
    assign load_data[d] = '{valid: 1'b1,
                            idx: lane_index(row.row_planes, row.mirror_horizontal,
                                            ColW'(d)),
                            sprite: row.sprite_mode,
                            col: ColW'(d),
                            last: (d == NumCols - 1)};
    if (d == NumCols - 1) begin : g_tail
      ptr_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .advance  (advance),
        .load     (load),
        .load_data(load_data[d]),
        .from_next('0),
        .cur      (cells[d])
      );
    end else begin : g_body
      ptr_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .advance  (advance),
        .load     (load),
        .load_data(load_data[d]),
        .from_next(cells[d+1]),
        .cur      (cells[d])
      );
    end
  end

  ptr_palette u_palette (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .prdata(prdata),
    .entry ({head.sprite, head.idx}),
    .raw   (raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (advance) begin
      pixel.valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel.pixel_column <= head.col;
      pixel.last_pixel   <= head.last;
      if (head.sprite && head.idx == '0) begin
        pixel.write_enable <= 1'b0;
        pixel.pixel_rgb    <= '0;
      end else begin
        pixel.write_enable <= 1'b1;
        pixel.pixel_rgb    <= expand_rgb(raw);
      end
    end
  end

`ifndef SYNTHESIS
  a_load_fills_tail: assert property (@(posedge clk) disable iff (rst)
    row.valid && row.ready |=> cells[NumCols-1].valid && cells[NumCols-1].last)
    else $error("accepted row did not fill the chain");

  a_chain_contiguous: assert property (@(posedge clk) disable iff (rst)
    !cells[1].valid |-> !cells[2].valid)
    else $error("hole in the cell chain");

  a_last_on_col7: assert property (@(posedge clk) disable iff (rst)
    pixel.valid |-> (pixel.last_pixel == (pixel.pixel_column == 3'd7)))
    else $error("last flag not on column 7");

  a_transparent_black: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && !pixel.write_enable |-> pixel.pixel_rgb == '0)
    else $error("transparent pixel carries colour");
`endif

endmodule
